>>> src/bqs_pkg.sv
// Shared types and constants for the bounded queue with search.
// Holds the operation and status codes and the controller/datapath structs.
// No dependencies.
package bqs_pkg;

  localparam int unsigned CAPACITY_DEF   = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UPDATE = 2'd3
  } bqs_cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } bqs_status_e;

  // Which queue position the single memory port addresses.
  typedef enum logic [1:0] {
    ADDR_TAIL = 2'd0,
    ADDR_HEAD = 2'd1,
    ADDR_NEXT = 2'd2,
    ADDR_SLOT = 2'd3
  } bqs_addr_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch_in;
    logic        mem_we;
    logic        rd_en;
    bqs_addr_e   addr_sel;
    logic        head_adv;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        pos_clr;
    logic        pos_inc;
    logic        res_ld;
    bqs_status_e res_code;
    logic        found_ld;
    logic        dout_ld;
    logic        out_ld;
  } bqs_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    bqs_cmd_e cmd;
    logic     empty;
    logic     full;
    logic     slot_ok;
    logic     match;
    logic     last_pos;
    logic     out_free;
  } bqs_stat_t;

endpackage

>>> src/bqs_dpath.sv
// Datapath of the bounded queue with search: entry store, pointers and result registers.
// Driven by bqs_ctrl through bqs_pkg::bqs_ctrl_t; depends on bqs_pkg.
module bqs_dpath #(
  parameter int unsigned CAPACITY   = bqs_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = bqs_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bqs_pkg::bqs_ctrl_t ctrl_i,
  output bqs_pkg::bqs_stat_t stat_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         slot_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic [3:0]         found_slot_o,
  output logic signed [31:0] data_out_o,
  output logic [3:0]         occupancy_o,
  output logic               is_full_o,
  output logic               is_empty_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned OW    = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [DATA_WIDTH-1:0] val_in;
  logic [DATA_WIDTH-1:0] val_q;
  bqs_pkg::bqs_cmd_e     cmd_q;
  logic [3:0]            slot_q;
  logic [IDX_W-1:0]      head_q;
  logic [CNT_W-1:0]      count_q;
  logic [IDX_W-1:0]      pos_q;

  logic [2:0]            res_status_q;
  logic [3:0]            res_found_q;
  logic [31:0]           res_dout_q;

  logic                  out_valid_q;
  logic [2:0]            out_status_q;
  logic [3:0]            out_found_q;
  logic [31:0]           out_data_q;
  logic [3:0]            out_occ_q;
  logic                  out_full_q;
  logic                  out_empty_q;

  logic [IDX_W-1:0]      offset;
  logic [IDX_W-1:0]      addr;
  logic [OW-1:0]         slot_ext;
  logic [OW-1:0]         cnt_ext;
  logic [OW-1:0]         slot_m1;
  logic [CNT_W-1:0]      pos_p1;
  logic [OW-1:0]         pos_p1_ext;
  logic [31:0]           dout_ext;
  logic                  full;

  // Store position to physical index; the sum stays below twice the capacity.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= CAP_SUM) begin
      sum = sum - CAP_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  if (DATA_WIDTH <= 32) begin : g_in_narrow
    assign val_in = value_i[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign val_in = {{(DATA_WIDTH - 32){value_i[31]}}, value_i};
  end

  if (DATA_WIDTH >= 32) begin : g_out_wide
    assign dout_ext = rd_data_q[31:0];
  end else begin : g_out_narrow
    assign dout_ext = {{(32 - DATA_WIDTH){rd_data_q[DATA_WIDTH-1]}}, rd_data_q};
  end

  assign slot_ext   = OW'(slot_q);
  assign cnt_ext    = OW'(count_q);
  assign slot_m1    = slot_ext - OW'(1);
  assign pos_p1     = CNT_W'(pos_q) + CNT_W'(1);
  assign pos_p1_ext = OW'(pos_p1);
  assign full       = (count_q == CAP_CNT);

  always_comb begin
    unique case (ctrl_i.addr_sel)
      bqs_pkg::ADDR_TAIL: offset = count_q[IDX_W-1:0];
      bqs_pkg::ADDR_HEAD: offset = '0;
      bqs_pkg::ADDR_NEXT: offset = pos_q + IDX_W'(1);
      bqs_pkg::ADDR_SLOT: offset = slot_m1[IDX_W-1:0];
      default:            offset = '0;
    endcase
  end

  assign addr = phys(head_q, offset);

  // Entry store: one port, registered read data.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_we) begin
      mem_q[addr] <= val_q;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[addr];
    end
  end

  // Captured operation and search position.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      cmd_q  <= bqs_pkg::bqs_cmd_e'(cmd_i);
      val_q  <= val_in;
      slot_q <= slot_i;
    end
    if (ctrl_i.pos_clr) begin
      pos_q <= '0;
    end else if (ctrl_i.pos_inc) begin
      pos_q <= pos_q + IDX_W'(1);
    end
  end

  // Result being built for the current operation.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      res_found_q <= '0;
      res_dout_q  <= '0;
    end else begin
      if (ctrl_i.found_ld) begin
        res_found_q <= pos_p1_ext[3:0];
      end
      if (ctrl_i.dout_ld) begin
        res_dout_q <= dout_ext;
      end
    end
    if (ctrl_i.res_ld) begin
      res_status_q <= ctrl_i.res_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.head_adv) begin
        head_q <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
      end
      if (ctrl_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end else if (ctrl_i.cnt_dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (ctrl_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register; counts already reflect the finished operation.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_ld) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_data_q   <= res_dout_q;
      out_occ_q    <= cnt_ext[3:0];
      out_full_q   <= full;
      out_empty_q  <= (count_q == '0);
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = full;
  assign stat_o.slot_ok  = (slot_q != 4'd0) && (slot_ext <= cnt_ext);
  assign stat_o.match    = (rd_data_q == val_q);
  assign stat_o.last_pos = (pos_p1 == count_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_slot_o = out_found_q;
  assign data_out_o   = out_data_q;
  assign occupancy_o  = out_occ_q;
  assign is_full_o    = out_full_q;
  assign is_empty_o   = out_empty_q;

endmodule

>>> src/bqs_ctrl.sv
// Controller of the bounded queue with search: sequences each operation.
// Drives bqs_dpath through bqs_pkg::bqs_ctrl_t; depends on bqs_pkg.
module bqs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bqs_pkg::bqs_stat_t stat_i,
  output bqs_pkg::bqs_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DEL_RD,
    S_SEARCH,
    S_FINISH
  } state_e;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    ctrl_o            = '0;
    ctrl_o.addr_sel   = bqs_pkg::ADDR_HEAD;
    ctrl_o.res_code   = bqs_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.latch_in = 1'b1;
          state_d         = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctrl_o.res_ld = 1'b1;
        state_d       = S_FINISH;
        unique case (stat_i.cmd)
          bqs_pkg::CMD_INSERT: begin
            if (stat_i.full) begin
              ctrl_o.res_code = bqs_pkg::ST_FULL;
            end else begin
              ctrl_o.addr_sel = bqs_pkg::ADDR_TAIL;
              ctrl_o.mem_we   = 1'b1;
              ctrl_o.cnt_inc  = 1'b1;
            end
          end
          bqs_pkg::CMD_DELETE: begin
            if (stat_i.empty) begin
              ctrl_o.res_code = bqs_pkg::ST_EMPTY;
            end else begin
              ctrl_o.rd_en    = 1'b1;
              ctrl_o.head_adv = 1'b1;
              ctrl_o.cnt_dec  = 1'b1;
              state_d         = S_DEL_RD;
            end
          end
          bqs_pkg::CMD_SEARCH: begin
            if (stat_i.empty) begin
              ctrl_o.res_code = bqs_pkg::ST_EMPTY;
            end else begin
              ctrl_o.rd_en   = 1'b1;
              ctrl_o.pos_clr = 1'b1;
              state_d        = S_SEARCH;
            end
          end
          bqs_pkg::CMD_UPDATE: begin
            if (stat_i.empty) begin
              ctrl_o.res_code = bqs_pkg::ST_EMPTY;
            end else if (!stat_i.slot_ok) begin
              ctrl_o.res_code = bqs_pkg::ST_BADPOS;
            end else begin
              ctrl_o.addr_sel = bqs_pkg::ADDR_SLOT;
              ctrl_o.mem_we   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_DEL_RD: begin
        ctrl_o.dout_ld = 1'b1;
        state_d        = S_FINISH;
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          ctrl_o.found_ld = 1'b1;
          ctrl_o.res_ld   = 1'b1;
          state_d         = S_FINISH;
        end else if (stat_i.last_pos) begin
          ctrl_o.res_ld   = 1'b1;
          ctrl_o.res_code = bqs_pkg::ST_NOTFOUND;
          state_d         = S_FINISH;
        end else begin
          ctrl_o.addr_sel = bqs_pkg::ADDR_NEXT;
          ctrl_o.rd_en    = 1'b1;
          ctrl_o.pos_inc  = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.out_ld = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> src/bounded_queue_with_search_core.sv
// Top level of the bounded queue with search: a FIFO of signed values with
// insert, delete, search and update-at-position; joins bqs_ctrl and bqs_dpath.
// Depends on bqs_pkg, bqs_ctrl and bqs_dpath.
//
//   Channel  Direction  Handshake               Beat contents
//   in       input      in_valid_i/in_stall_o   cmd_i, value_i, slot_i
//   out      output     out_valid_o/out_stall_i status_o, found_slot_o, data_out_o,
//                                                occupancy_o, is_full_o, is_empty_o
//
// Each operation passes through an acceptance, a decision and a finish state;
// delete adds a state for the store read, and search compares one entry at a time
// (entries one to k for a match at position k, all occupied entries when none).
// Search is bounded by the single port of the entry store, read once per cycle.
// Reset clears the head pointer, entry count, controller state and output valid;
// the store itself holds no reset value and is only read where it was written.
// The result sits in an output register, so a new beat is taken while it waits;
// a stalled output holds the controller in its finish state until the slot frees.
module bounded_queue_with_search_core #(
  parameter int unsigned CAPACITY   = bqs_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = bqs_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [3:0]         found_slot_o,
  output logic signed [31:0] data_out_o,
  output logic [3:0]         occupancy_o,
  output logic               is_full_o,
  output logic               is_empty_o
);

  // Command and status paths between the controller and the datapath.
  bqs_pkg::bqs_ctrl_t ctrl;
  bqs_pkg::bqs_stat_t stat;

  // The controller sequences an operation through its states and owns the
  // input stall: a new beat is only taken in its idle state.
  bqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The datapath holds the circular store, head and count, the search position
  // and the output register that drives the result channel.
  bqs_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .slot_i       (slot_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .found_slot_o (found_slot_o),
    .data_out_o   (data_out_o),
    .occupancy_o  (occupancy_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

endmodule
